[hw/rtl/assert_macros.svh]
// ============================================================================
// Assertion macros
// Concurrent assertion shorthands shared by the RTL. They vanish when SYNTH
// is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/uyvy_ds_pkg.sv]
// ============================================================================
// UYVY downscaler package
// Sum record, register indexes, reset values and the saturating helpers.
// ============================================================================
package uyvy_ds_pkg;

  // Packed luma and chroma sums of a partial or complete block.
  typedef struct packed {
    logic [13:0] y;
    logic [12:0] u;
    logic [12:0] v;
  } sums_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SCALE_LOG2   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd520;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd240;
  localparam logic [1:0]  RST_SCALE_LOG2   = 2'd1;

  // Largest mean (255 * 64) and the chroma center (127.5 * 64).
  localparam logic [13:0] MEAN_MAX = 14'd16320;
  localparam logic [13:0] CENTER   = 14'd8160;

  // Field-wise add, each field saturating at its all-ones value.
  function automatic sums_t sums_add(sums_t a, sums_t b);
    logic [14:0] y;
    logic [13:0] u;
    logic [13:0] v;
    sums_t       r;
    y = {1'b0, a.y} + {1'b0, b.y};
    u = {1'b0, a.u} + {1'b0, b.u};
    v = {1'b0, a.v} + {1'b0, b.v};
    r.y = y[14] ? '1 : y[13:0];
    r.u = u[13] ? '1 : u[12:0];
    r.v = v[13] ? '1 : v[12:0];
    return r;
  endfunction

  // Clamp a scaled mean to the top of the sample range.
  function automatic logic [13:0] mean_sat(logic [17:0] m);
    return (m > 18'(MEAN_MAX)) ? MEAN_MAX : m[13:0];
  endfunction

  // Remove the chroma offset; the result is two's complement.
  function automatic logic signed [13:0] chroma_center(logic [13:0] m);
    return signed'(m - CENTER);
  endfunction

endpackage

[hw/rtl/uyvy_box_downscale_to_yuv_core.sv]
// ============================================================================
// UYVY box downscaler core
// Averages F x F pixel blocks of a UYVY raster stream into fixed-point YUV.
// ============================================================================
// Usage: each input word is one UYVY macropixel in raster order, with
// start_of_frame_i marking the first word of a frame. Each output word is one
// downscaled pixel: mean luma times 64, mean chroma times 64 minus 8160, its
// column and line in the downscaled image, a flag on the last pixel caused by
// the input word and a flag on the last pixel of the frame. Both channels use
// valid and stall; a word moves on a clock edge with valid high, stall low.
// An accepted word is registered in stage 1, then in the output register, and
// its result leaves from there. At factor 1 every input word gives two output
// words, so the single output port sets how fast the block takes words. At
// factors 2, 4 and 8 it takes one word per cycle while the output does not
// stall; the column-sum line store is read when a word is accepted and
// written when that word leaves the next stage, with a bypass for back-to-back
// hits on the same column. When the receiver stalls, the output register holds
// its word and the stage before it fills; after that the input stalls.
// Reset empties the pipeline, zeroes the position and the running row sum and
// loads the default configuration; the line store is not cleared, as the first
// line of every block row overwrites it. The user must write configuration
// through the plain write port while the block is idle; it is not enforced.
// ============================================================================
`include "assert_macros.svh"

module uyvy_box_downscale_to_yuv_core
  import uyvy_ds_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [10:0]        cfg_data_i,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               start_of_frame_i,
  input  logic [7:0]         cb_sample_i,
  input  logic [7:0]         luma_first_i,
  input  logic [7:0]         cr_sample_i,
  input  logic [7:0]         luma_second_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [13:0]        luma_mean_o,
  output logic signed [13:0] cb_centered_o,
  output logic signed [13:0] cr_centered_o,
  output logic [9:0]         out_column_o,
  output logic [9:0]         out_line_o,
  output logic               last_of_run_o,
  output logic               end_of_frame_o
);

  // Macropixel columns of a line, and the widths that follow from the limits.
  localparam int COLS = MAX_WIDTH / 2;
  localparam int AW   = $clog2(COLS);           // macropixel index
  localparam int CW   = AW + 1;                 // macropixel count
  localparam int LW   = $clog2(MAX_HEIGHT);     // line index
  localparam int HW   = LW + 1;                 // line count
  localparam int GCW  = (CW > 10) ? CW : 10;    // compare width for the width clamp
  localparam int HCW  = (HW > 11) ? HW : 11;    // compare width for the height clamp
  localparam int XW   = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int LXW  = (LW > 10) ? LW : 10;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [10:0] frame_width_q;
  logic [10:0] frame_height_q;
  logic [1:0]  scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      scale_q        <= RST_SCALE_LOG2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_SCALE_LOG2:   scale_q        <= cfg_data_i[1:0];
        default:          ;
      endcase
    end
  end

  // Effective frame size. The width counts macropixels and is clamped to
  // one through the line store depth; the height is clamped likewise.
  logic [GCW-1:0] width_half;
  logic [HCW-1:0] height_ext;
  logic [CW-1:0]  groups;
  logic [HW-1:0]  height;

  assign width_half = GCW'(frame_width_q[10:1]);
  assign height_ext = HCW'(frame_height_q);

  always_comb begin
    if (width_half == '0) begin
      groups = CW'(1);
    end else if (width_half > GCW'(COLS)) begin
      groups = CW'(COLS);
    end else begin
      groups = CW'(width_half);
    end
    if (height_ext == '0) begin
      height = HW'(1);
    end else if (height_ext > HCW'(MAX_HEIGHT)) begin
      height = HW'(MAX_HEIGHT);
    end else begin
      height = HW'(height_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_pair_q;
  logic out_sel_q;
  logic out_free;
  logic s1_adv;
  logic in_accept;

  // The output register frees up when it is empty or its final word leaves.
  assign out_free   = !out_valid_q || (!out_stall_i && (!out_pair_q || out_sel_q));
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Position tracking at the input
  // --------------------------------------------------------------------------
  logic [AW-1:0] gpos_q, gpos_d;
  logic [LW-1:0] lpos_q, lpos_d;
  logic [AW-1:0] g0, g;
  logic [LW-1:0] l0, l;
  logic [HW-1:0] l1;
  logic [CW-1:0] g_next;
  logic [HW-1:0] l_next;

  always_comb begin
    g0 = start_of_frame_i ? '0 : gpos_q;
    l0 = start_of_frame_i ? '0 : lpos_q;
    // A macropixel index beyond the line starts the next line.
    if (CW'(g0) >= groups) begin
      g  = '0;
      l1 = HW'(l0) + HW'(1);
    end else begin
      g  = g0;
      l1 = HW'(l0);
    end
    l = (l1 >= height) ? '0 : LW'(l1);

    // Position after this macropixel.
    g_next = CW'(g) + CW'(1);
    l_next = HW'(l) + HW'(1);
    if (g_next >= groups) begin
      gpos_d = '0;
      lpos_d = (l_next >= height) ? '0 : LW'(l_next);
    end else begin
      gpos_d = AW'(g_next);
      lpos_d = l;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpos_q <= '0;
      lpos_q <= '0;
    end else if (in_accept) begin
      gpos_q <= gpos_d;
      lpos_q <= lpos_d;
    end
  end

  // --------------------------------------------------------------------------
  // Block geometry of the accepted macropixel
  // --------------------------------------------------------------------------
  logic [2:0]     half_mask;   // macropixels per block row, minus one
  logic [2:0]     f_mask;      // lines per block, minus one
  logic [AW-1:0]  col;         // line store address; the output column at factors 2, 4 and 8
  logic [CW-1:0]  out_w;
  logic [HW-1:0]  out_h;
  logic [LW-1:0]  line_sh;
  logic           off_zero, off_last, r_zero, r_last;
  logic           blk_wr, blk_emit, eof_in;
  logic [XW-1:0]  col_x;
  logic [LXW-1:0] line_x;
  logic [9:0]     col_in, line_in;
  sums_t          item, ps_q, ps_d;

  always_comb begin
    unique case (scale_q)
      2'd0: begin
        half_mask = 3'd0; f_mask = 3'd0;
        col = g; out_w = groups; out_h = height; line_sh = l;
      end
      2'd1: begin
        half_mask = 3'd0; f_mask = 3'd1;
        col = g; out_w = groups; out_h = height >> 1; line_sh = l >> 1;
      end
      2'd2: begin
        half_mask = 3'd1; f_mask = 3'd3;
        col = g >> 1; out_w = groups >> 1; out_h = height >> 2; line_sh = l >> 2;
      end
      default: begin
        half_mask = 3'd3; f_mask = 3'd7;
        col = g >> 2; out_w = groups >> 2; out_h = height >> 3; line_sh = l >> 3;
      end
    endcase
  end

  assign off_zero = (g[2:0] & half_mask) == 3'd0;
  assign off_last = (g[2:0] & half_mask) == half_mask;
  assign r_zero   = (l[2:0] & f_mask) == 3'd0;
  assign r_last   = (l[2:0] & f_mask) == f_mask;

  // At factor 1 every macropixel passes straight through.
  assign blk_wr   = (scale_q != 2'd0) && off_last;
  assign blk_emit = blk_wr && r_last;

  always_comb begin
    if (scale_q == 2'd0) begin
      eof_in = (CW'(g) == groups - CW'(1)) && (HW'(l) == height - HW'(1));
      col_x  = XW'({g, 1'b0});
    end else begin
      eof_in = (CW'(col) + CW'(1) == out_w) && (HW'(line_sh) + HW'(1) == out_h);
      col_x  = XW'(col);
    end
  end

  assign line_x  = LXW'(line_sh);
  assign col_in  = col_x[9:0];
  assign line_in = line_x[9:0];

  // Running sum over the macropixels of one block row.
  assign item.y = 14'({1'b0, luma_first_i} + {1'b0, luma_second_i});
  assign item.u = 13'(cb_sample_i);
  assign item.v = 13'(cr_sample_i);
  assign ps_d   = off_zero ? item : sums_add(ps_q, item);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= '0;
    end else if (in_accept && (scale_q != 2'd0)) begin
      ps_q <= ps_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line store access
  // --------------------------------------------------------------------------
  logic          s1_wr_q, s1_rzero_q, s1_emit_q, s1_eof_q;
  logic [1:0]    s1_scale_q;
  logic [AW-1:0] s1_addr_q;
  logic [9:0]    s1_col_q, s1_line_q;
  logic [7:0]    s1_u_q, s1_v_q, s1_y1_q, s1_y2_q;
  sums_t         s1_ps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_wr_q    <= blk_wr;
      s1_rzero_q <= r_zero;
      s1_emit_q  <= blk_emit;
      s1_eof_q   <= eof_in;
      s1_scale_q <= scale_q;
      s1_addr_q  <= col;
      s1_col_q   <= col_in;
      s1_line_q  <= line_in;
      s1_u_q     <= cb_sample_i;
      s1_v_q     <= cr_sample_i;
      s1_y1_q    <= luma_first_i;
      s1_y2_q    <= luma_second_i;
      s1_ps_q    <= (scale_q != 2'd0) ? ps_d : ps_q;
    end
  end

  // Line store of column sums: read on accept, written as stage 1 leaves.
  sums_t col_mem [COLS];
  sums_t rd_data_q;
  sums_t byp_data_q;
  logic  byp_q;
  sums_t col_rd;
  sums_t col_new;
  logic  mem_we;

  assign col_rd  = byp_q ? byp_data_q : rd_data_q;
  assign col_new = s1_rzero_q ? s1_ps_q : sums_add(col_rd, s1_ps_q);
  assign mem_we  = s1_adv && s1_wr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      col_mem[s1_addr_q] <= col_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_data_q <= col_mem[col];
    end
  end

  // A read that meets a write to the same column on one edge takes the
  // value being written instead of the stale array contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_accept) begin
      byp_q <= mem_we && (s1_addr_q == col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byp_data_q <= col_new;
    end
  end

  // Scale the block sums to 6 fraction bits: luma has F*F samples and
  // chroma F*F/2, so the shifts differ by one.
  logic [17:0] y_scaled, u_scaled, v_scaled;

  always_comb begin
    unique case (s1_scale_q)
      2'd1: begin
        y_scaled = 18'(col_new.y) << 4;
        u_scaled = 18'(col_new.u) << 5;
        v_scaled = 18'(col_new.v) << 5;
      end
      2'd2: begin
        y_scaled = 18'(col_new.y) << 2;
        u_scaled = 18'(col_new.u) << 3;
        v_scaled = 18'(col_new.v) << 3;
      end
      2'd3: begin
        y_scaled = 18'(col_new.y);
        u_scaled = 18'(col_new.u) << 1;
        v_scaled = 18'(col_new.v) << 1;
      end
      default: begin
        y_scaled = 18'({s1_y1_q, 6'b0});
        u_scaled = 18'({s1_u_q, 6'b0});
        v_scaled = 18'({s1_v_q, 6'b0});
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: one block pixel, or a pixel pair at factor 1
  // --------------------------------------------------------------------------
  logic              out_valid_d, out_pair_d, out_sel_d;
  logic [13:0]       out_luma0_q, out_luma1_q;
  logic signed [13:0] out_cb_q, out_cr_q;
  logic [9:0]        out_col_q, out_line_q;
  logic              out_eof_q;
  logic              s1_pair;

  assign s1_pair = (s1_scale_q == 2'd0);

  always_comb begin
    out_valid_d = out_valid_q;
    out_pair_d  = out_pair_q;
    out_sel_d   = out_sel_q;
    if (s1_adv) begin
      out_valid_d = s1_pair || s1_emit_q;
      out_pair_d  = s1_pair;
      out_sel_d   = 1'b0;
    end else if (out_valid_q && !out_stall_i) begin
      if (out_pair_q && !out_sel_q) begin
        out_sel_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
        out_sel_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_pair_q  <= 1'b0;
      out_sel_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      out_pair_q  <= out_pair_d;
      out_sel_q   <= out_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_luma0_q <= mean_sat(y_scaled);
      out_luma1_q <= {s1_y2_q, 6'b0};
      out_cb_q    <= chroma_center(mean_sat(u_scaled));
      out_cr_q    <= chroma_center(mean_sat(v_scaled));
      out_col_q   <= s1_col_q;
      out_line_q  <= s1_line_q;
      out_eof_q   <= s1_eof_q;
    end
  end

  // The second pixel of a pair sits in the odd column next to the first.
  assign out_valid_o    = out_valid_q;
  assign luma_mean_o    = out_sel_q ? out_luma1_q : out_luma0_q;
  assign cb_centered_o  = out_cb_q;
  assign cr_centered_o  = out_cr_q;
  assign out_column_o   = out_sel_q ? {out_col_q[9:1], 1'b1} : out_col_q;
  assign out_line_o     = out_line_q;
  assign last_of_run_o  = !out_pair_q || out_sel_q;
  assign end_of_frame_o = out_eof_q && last_of_run_o;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The second word of a pair is only ever shown for a held pair.
  `ASSERT_IMPL(a_sel_in_pair, clk_i, rst_ni, out_sel_q, out_pair_q && out_valid_q)
  // A finished block always comes from a line store write.
  `ASSERT_IMPL(a_emit_has_write, clk_i, rst_ni, s1_valid_q && s1_emit_q, s1_wr_q)
  // The pair moves to its second word only after the first was taken.
  `ASSERT_IMPL(a_sel_after_take, clk_i, rst_ni, $rose(out_sel_q),
               $past(out_valid_o && !out_stall_i))
  // A bypass only follows an edge at which the line store was written.
  `ASSERT_NEXT(a_bypass_source, clk_i, rst_ni, in_accept && !mem_we, !byp_q)

endmodule
